>>> rtl/icsp_pkg.sv
// Shared types, codes and constants of the serial programming master.
`timescale 1ns / 1ps

package icsp_pkg;

  // Entry key and its length.
  localparam int unsigned KEY_BITS = 32;
  localparam logic [KEY_BITS-1:0] ENTRY_KEY = 32'h4D43_4850;

  // Fixed gap used around the entry sequence, in microseconds.
  localparam logic [15:0] FIXED_GAP_US = 16'd10;

  // Operation codes.
  localparam logic [1:0] CMD_ENTER = 2'd0;
  localparam logic [1:0] CMD_EXIT  = 2'd1;
  localparam logic [1:0] CMD_XFER  = 2'd2;
  localparam logic [1:0] CMD_PULSE = 2'd3;

  // Slot kinds.
  localparam logic [1:0] KIND_FALL   = 2'd0;
  localparam logic [1:0] KIND_RISE   = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;
  localparam logic [1:0] KIND_STATIC = 2'd3;

  // Serial codes that read a reply byte.
  localparam logic [3:0] CODE_READ_TABLE = 4'h2;
  localparam logic [3:0] CODE_READ_LO    = 4'h8;
  localparam logic [3:0] CODE_READ_HI    = 4'hB;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A_CODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A_DATA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PROG    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DISCH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY   = 3'd7;

  // Reset values of the timing registers.
  localparam logic [15:0] RST_SETUP  = 16'd1;
  localparam logic [15:0] RST_HOLD   = 16'd1;
  localparam logic [15:0] RST_A_CODE = 16'd1;
  localparam logic [15:0] RST_A_DATA = 16'd1;
  localparam logic [15:0] RST_TURN   = 16'd1;
  localparam logic [15:0] RST_PROG   = 16'd2000;
  localparam logic [15:0] RST_DISCH  = 16'd200;
  localparam logic [15:0] RST_ENTRY  = 16'd500;

  // One operation.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  icsp_code;
    logic [15:0] payload;
    logic [7:0]  target_reply;
  } in_item_t;

  // One pin slot.
  typedef struct packed {
    logic [1:0]  slot_kind;
    logic        clock_level;
    logic        data_level;
    logic        data_driven;
    logic        reset_level;
    logic [15:0] wait_us;
    logic [7:0]  read_byte;
    logic        last;
  } out_item_t;

  // Timing register file contents.
  typedef struct packed {
    logic [15:0] setup_time_us;
    logic [15:0] hold_time_us;
    logic [15:0] after_code_us;
    logic [15:0] after_data_us;
    logic [15:0] read_turnaround_us;
    logic [15:0] program_time_us;
    logic [15:0] discharge_time_us;
    logic [15:0] entry_wait_us;
  } cfg_regs_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EN_R0,
    ST_EN_R1,
    ST_EN_R2,
    ST_EN_KEY,
    ST_EN_G0,
    ST_EN_G1,
    ST_EX_R0,
    ST_EX_R1,
    ST_EX_R2,
    ST_TR_CODE,
    ST_TR_CGAP,
    ST_TR_IDLE,
    ST_TR_TURN,
    ST_TR_SAMP,
    ST_TR_RDONE,
    ST_WR_DATA,
    ST_DATA_DONE,
    ST_PU_CLK,
    ST_PU_HIGH,
    ST_PU_DIS
  } seq_state_t;

  // True for codes that read a reply byte.
  function automatic logic is_read_code(input logic [3:0] code);
    return (code == CODE_READ_TABLE) || ((code >= CODE_READ_LO) && (code <= CODE_READ_HI));
  endfunction

endpackage

>>> rtl/icsp_cfg_regs.sv
// Timing register file written through the configuration port.
`timescale 1ns / 1ps

module icsp_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [icsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_wdata,
  output icsp_pkg::cfg_regs_t             regs
);
  import icsp_pkg::*;

  cfg_regs_t regs_r;

  // Registers load their reset timings and take writes one at a time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.setup_time_us      <= RST_SETUP;
      regs_r.hold_time_us       <= RST_HOLD;
      regs_r.after_code_us      <= RST_A_CODE;
      regs_r.after_data_us      <= RST_A_DATA;
      regs_r.read_turnaround_us <= RST_TURN;
      regs_r.program_time_us    <= RST_PROG;
      regs_r.discharge_time_us  <= RST_DISCH;
      regs_r.entry_wait_us      <= RST_ENTRY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETUP:  regs_r.setup_time_us      <= cfg_wdata;
        REG_HOLD:   regs_r.hold_time_us       <= cfg_wdata;
        REG_A_CODE: regs_r.after_code_us      <= cfg_wdata;
        REG_A_DATA: regs_r.after_data_us      <= cfg_wdata;
        REG_TURN:   regs_r.read_turnaround_us <= cfg_wdata;
        REG_PROG:   regs_r.program_time_us    <= cfg_wdata;
        REG_DISCH:  regs_r.discharge_time_us  <= cfg_wdata;
        REG_ENTRY:  regs_r.entry_wait_us      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign regs = regs_r;

endmodule

>>> rtl/icsp_slot_seq.sv
// Slot sequencer: shifts the key, code, payload and reply one bit per slot.
`timescale 1ns / 1ps

module icsp_slot_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  icsp_pkg::in_item_t    item,
  input  icsp_pkg::cfg_regs_t   regs,
  input  logic                  slot_take,
  output logic                  busy,
  output logic                  slot_valid,
  output icsp_pkg::out_item_t   slot
);
  import icsp_pkg::*;

  seq_state_t state_r, state_nxt;
  logic [KEY_BITS-1:0] shift_r, shift_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic [7:0]          rx_r, rx_nxt;
  logic                rd_r, rd_nxt;
  logic                rl_r, rl_nxt;

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      rd_r    <= 1'b0;
      rl_r    <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rd_r    <= rd_nxt;
      rl_r    <= rl_nxt;
    end
  end

  // Data shift registers.
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    rx_r    <= rx_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign slot_valid = busy;

  // Slot contents and next state; the sequencer moves on when a slot is taken.
  always_comb begin
    state_nxt = state_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    rx_nxt    = rx_r;
    rd_nxt    = rd_r;
    rl_nxt    = rl_r;

    slot.slot_kind   = KIND_STATIC;
    slot.clock_level = 1'b0;
    slot.data_level  = 1'b0;
    slot.data_driven = 1'b1;
    slot.reset_level = rl_r;
    slot.wait_us     = regs.hold_time_us;
    slot.read_byte   = '0;
    slot.last        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          rd_nxt = is_read_code(item.icsp_code);
          case (item.cmd)
            CMD_ENTER: begin
              state_nxt = ST_EN_R0;
              shift_nxt = ENTRY_KEY;
            end
            CMD_EXIT: begin
              state_nxt = ST_EX_R0;
            end
            CMD_XFER: begin
              state_nxt = ST_TR_CODE;
              cnt_nxt   = 5'd3;
              if (is_read_code(item.icsp_code)) begin
                shift_nxt = {20'b0, item.target_reply, item.icsp_code};
              end else begin
                shift_nxt = {12'b0, item.payload, item.icsp_code};
              end
            end
            CMD_PULSE: begin
              state_nxt = ST_PU_CLK;
              cnt_nxt   = 5'd2;
              shift_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Entry: reset low, high, low, then the key MSB first, then reset low and high.
      ST_EN_R0: begin
        slot.reset_level = 1'b0;
        if (slot_take) state_nxt = ST_EN_R1;
      end
      ST_EN_R1: begin
        slot.reset_level = 1'b1;
        slot.wait_us     = FIXED_GAP_US;
        if (slot_take) state_nxt = ST_EN_R2;
      end
      ST_EN_R2: begin
        slot.reset_level = 1'b0;
        slot.wait_us     = regs.entry_wait_us;
        if (slot_take) begin
          state_nxt = ST_EN_KEY;
          cnt_nxt   = 5'(KEY_BITS - 1);
          rl_nxt    = 1'b0;
        end
      end
      ST_EN_KEY: begin
        slot.slot_kind   = KIND_RISE;
        slot.data_level  = shift_r[KEY_BITS-1];
        slot.reset_level = 1'b0;
        if (slot_take) begin
          shift_nxt = {shift_r[KEY_BITS-2:0], 1'b0};
          cnt_nxt   = cnt_r - 5'd1;
          if (cnt_r == '0) state_nxt = ST_EN_G0;
        end
      end
      ST_EN_G0: begin
        slot.reset_level = 1'b0;
        slot.wait_us     = FIXED_GAP_US;
        if (slot_take) begin
          state_nxt = ST_EN_G1;
          rl_nxt    = 1'b1;
        end
      end
      ST_EN_G1: begin
        slot.reset_level = 1'b1;
        slot.wait_us     = FIXED_GAP_US;
        slot.last        = 1'b1;
        if (slot_take) state_nxt = ST_IDLE;
      end

      // Exit: lines low, reset pulsed low and released.
      ST_EX_R0: begin
        if (slot_take) state_nxt = ST_EX_R1;
      end
      ST_EX_R1: begin
        slot.reset_level = 1'b0;
        if (slot_take) begin
          state_nxt = ST_EX_R2;
          rl_nxt    = 1'b1;
        end
      end
      ST_EX_R2: begin
        slot.reset_level = 1'b1;
        slot.wait_us     = '0;
        slot.last        = 1'b1;
        if (slot_take) state_nxt = ST_IDLE;
      end

      // Transfer: four code bits LSB first, then the gap.
      ST_TR_CODE: begin
        slot.slot_kind  = KIND_FALL;
        slot.data_level = shift_r[0];
        if (slot_take) begin
          shift_nxt = {1'b0, shift_r[KEY_BITS-1:1]};
          cnt_nxt   = cnt_r - 5'd1;
          if (cnt_r == '0) state_nxt = ST_TR_CGAP;
        end
      end
      ST_TR_CGAP: begin
        slot.wait_us = regs.after_code_us;
        if (slot_take) begin
          if (rd_r) begin
            state_nxt = ST_TR_IDLE;
            cnt_nxt   = 5'd7;
          end else begin
            state_nxt = ST_WR_DATA;
            cnt_nxt   = 5'd15;
          end
        end
      end

      // Read: idle clock slots, turnaround, eight sampled bits.
      ST_TR_IDLE: begin
        slot.slot_kind = KIND_FALL;
        if (slot_take) begin
          cnt_nxt = cnt_r - 5'd1;
          if (cnt_r == '0) state_nxt = ST_TR_TURN;
        end
      end
      ST_TR_TURN: begin
        slot.wait_us = regs.read_turnaround_us;
        if (slot_take) begin
          state_nxt = ST_TR_SAMP;
          cnt_nxt   = 5'd7;
        end
      end
      ST_TR_SAMP: begin
        slot.slot_kind   = KIND_SAMPLE;
        slot.data_level  = shift_r[0];
        slot.data_driven = 1'b0;
        if (slot_take) begin
          shift_nxt = {1'b0, shift_r[KEY_BITS-1:1]};
          rx_nxt    = {shift_r[0], rx_r[7:1]};
          cnt_nxt   = cnt_r - 5'd1;
          if (cnt_r == '0) state_nxt = ST_TR_RDONE;
        end
      end
      ST_TR_RDONE: begin
        slot.wait_us   = regs.after_data_us;
        slot.read_byte = rx_r;
        slot.last      = 1'b1;
        if (slot_take) state_nxt = ST_IDLE;
      end

      // Sixteen data bits LSB first, shared by writes and the pulse.
      ST_WR_DATA: begin
        slot.slot_kind  = KIND_FALL;
        slot.data_level = shift_r[0];
        if (slot_take) begin
          shift_nxt = {1'b0, shift_r[KEY_BITS-1:1]};
          cnt_nxt   = cnt_r - 5'd1;
          if (cnt_r == '0) state_nxt = ST_DATA_DONE;
        end
      end
      ST_DATA_DONE: begin
        slot.wait_us = regs.after_data_us;
        slot.last    = 1'b1;
        if (slot_take) state_nxt = ST_IDLE;
      end

      // Programming pulse: falling clock slots, clock held high, discharge.
      ST_PU_CLK: begin
        slot.slot_kind = KIND_FALL;
        if (slot_take) begin
          cnt_nxt = cnt_r - 5'd1;
          if (cnt_r == '0) state_nxt = ST_PU_HIGH;
        end
      end
      ST_PU_HIGH: begin
        slot.clock_level = 1'b1;
        slot.wait_us     = regs.program_time_us;
        if (slot_take) state_nxt = ST_PU_DIS;
      end
      ST_PU_DIS: begin
        slot.wait_us = regs.discharge_time_us;
        if (slot_take) begin
          state_nxt = ST_WR_DATA;
          cnt_nxt   = 5'd15;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The reset line is released whenever no operation is in progress.
  a_idle_reset_high: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> rl_r)
    else $error("reset line low while idle");

  // A started operation always leaves idle.
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && (state_r == ST_IDLE)) |=> (state_r != ST_IDLE))
    else $error("operation start ignored");

  // The final slot of an operation returns the sequencer to idle.
  a_last_ends_op: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_take && slot.last) |=> (state_r == ST_IDLE))
    else $error("sequencer busy after final slot");

  // Only the final slot of a read carries a reply byte.
  a_byte_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_valid && (slot.read_byte != '0)) |-> slot.last)
    else $error("reply byte on a non-final slot");

endmodule

>>> rtl/icsp_serial_programming_master_unit.sv
// Top level of the serial programming master: input transfer, output register, sequencer.
`timescale 1ns / 1ps

// Master side of a two-wire in-circuit serial programming link. Each input
// transfer is one operation (enter, exit, code transfer, programming pulse)
// and produces a run of pin slots on the output channel, the final one
// marked by last. The slot sequencer loads an operation while idle and
// then emits one slot per cycle while the output side keeps up: enter
// mode produces 37 slots, exit 3, a write transfer or a programming
// pulse 22, a read transfer 23. The sequencer's bit-serial shift
// register moves one key, code, data or reply bit per bit slot. A new
// operation is taken as soon as the final slot of the
// previous one has moved into the output register. Timing registers are to be
// written by the user only while the block is idle; the block itself does not enforce this.
module icsp_serial_programming_master_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  icsp_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output icsp_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [icsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_wdata
);
  import icsp_pkg::*;

  cfg_regs_t regs;
  out_item_t slot;
  out_item_t out_data_r;
  logic      out_valid_r;
  logic      busy;
  logic      slot_valid;
  logic      slot_take;
  logic      start;

  icsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  // An operation is accepted whenever the sequencer is free.
  assign in_stall = busy;
  assign start    = in_valid && !busy;

  icsp_slot_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .item       (in_data),
    .regs       (regs),
    .slot_take  (slot_take),
    .busy       (busy),
    .slot_valid (slot_valid),
    .slot       (slot)
  );

  // Output register: a slot moves in when the register is empty or being drained.
  assign slot_take = slot_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_take) begin
      out_data_r <= slot;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/testbench.sv
// Self-checking testbench of the serial programming master: operations in, pin slots out.
`timescale 1ns / 1ps
module testbench;
  import icsp_pkg::*;

  localparam int unsigned OPS_PER_PHASE    = 57;
  localparam int unsigned NUM_PHASES       = 5;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES    = 50;
  localparam int unsigned MAX_REPORTS      = 10;

  // Timing register settings used across the phases.
  typedef enum int {SET_ZERO, SET_ONES, SET_RANDOM, SET_MIXED, SET_RESET} timing_set_t;

  // One row of the directed sequence; typed rows carry the final slot by hand.
  typedef struct packed {
    in_item_t  op;
    logic      typed;
    out_item_t final_slot;
  } dir_row_t;

  // Final slots that follow directly from the reset timing values.
  localparam out_item_t END_EXIT  = '{KIND_STATIC, 1'b0, 1'b0, 1'b1, 1'b1, 16'd0, 8'h00, 1'b1};
  localparam out_item_t END_ENTER =
    '{KIND_STATIC, 1'b0, 1'b0, 1'b1, 1'b1, FIXED_GAP_US, 8'h00, 1'b1};
  localparam out_item_t END_PULSE =
    '{KIND_STATIC, 1'b0, 1'b0, 1'b1, 1'b1, RST_A_DATA, 8'h00, 1'b1};
  localparam out_item_t END_RD_00 =
    '{KIND_STATIC, 1'b0, 1'b0, 1'b1, 1'b1, RST_A_DATA, 8'h00, 1'b1};
  localparam out_item_t END_RD_FF =
    '{KIND_STATIC, 1'b0, 1'b0, 1'b1, 1'b1, RST_A_DATA, 8'hFF, 1'b1};
  localparam out_item_t END_RD_A5 =
    '{KIND_STATIC, 1'b0, 1'b0, 1'b1, 1'b1, RST_A_DATA, 8'hA5, 1'b1};

  // Directed operations: exit and transfers before entry, every code, pulses, re-entry, exit.
  localparam int unsigned NUM_DIRECTED = 23;
  localparam dir_row_t DIRECTED_OPS [NUM_DIRECTED] = '{
    '{'{CMD_EXIT,  4'h0, 16'h0000, 8'h00}, 1'b1, END_EXIT},
    '{'{CMD_XFER,  4'h0, 16'h0000, 8'h00}, 1'b0, '0},
    '{'{CMD_XFER,  4'h8, 16'hFFFF, 8'hFF}, 1'b1, END_RD_FF},
    '{'{CMD_ENTER, 4'hF, 16'hFFFF, 8'hFF}, 1'b1, END_ENTER},
    '{'{CMD_XFER,  4'h0, 16'hFFFF, 8'hFF}, 1'b0, '0},
    '{'{CMD_XFER,  4'h1, 16'hAAAA, 8'h55}, 1'b0, '0},
    '{'{CMD_XFER,  4'h2, 16'hFFFF, 8'h00}, 1'b1, END_RD_00},
    '{'{CMD_XFER,  4'h3, 16'h5555, 8'hAA}, 1'b0, '0},
    '{'{CMD_XFER,  4'h4, 16'h1234, 8'h00}, 1'b0, '0},
    '{'{CMD_XFER,  4'h5, 16'h8001, 8'hFF}, 1'b0, '0},
    '{'{CMD_XFER,  4'h6, 16'h7FFE, 8'h01}, 1'b0, '0},
    '{'{CMD_XFER,  4'h7, 16'h0F0F, 8'h80}, 1'b0, '0},
    '{'{CMD_XFER,  4'h9, 16'h0000, 8'hA5}, 1'b1, END_RD_A5},
    '{'{CMD_XFER,  4'hA, 16'hFFFF, 8'h5A}, 1'b0, '0},
    '{'{CMD_XFER,  4'hB, 16'h0000, 8'h81}, 1'b0, '0},
    '{'{CMD_XFER,  4'hC, 16'hF0F0, 8'h00}, 1'b0, '0},
    '{'{CMD_XFER,  4'hD, 16'h0001, 8'hFF}, 1'b0, '0},
    '{'{CMD_XFER,  4'hE, 16'h8000, 8'h00}, 1'b0, '0},
    '{'{CMD_XFER,  4'hF, 16'hFFFF, 8'hFF}, 1'b0, '0},
    '{'{CMD_PULSE, 4'h0, 16'h0000, 8'h00}, 1'b1, END_PULSE},
    '{'{CMD_PULSE, 4'hF, 16'hFFFF, 8'hFF}, 1'b0, '0},
    '{'{CMD_ENTER, 4'h0, 16'h0000, 8'h00}, 1'b0, '0},
    '{'{CMD_EXIT,  4'hF, 16'hFFFF, 8'hFF}, 1'b1, END_EXIT}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_wdata;

  // Predictor state: timing registers, reset line, and the slots still to come.
  logic [15:0] timing_reg [8];
  logic        reset_line_q;
  out_item_t   expected_slots [$];

  int unsigned mismatches = 0;
  logic        idle_enable = 1'b1;
  logic        pressure_start = 1'b0;
  logic        long_hold = 1'b0;
  int unsigned stall_run = 0;

  icsp_serial_programming_master_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Queue one expected pin slot.
  function automatic void add_slot(input logic [1:0] kind, input logic clk_lvl,
                                   input logic dat, input logic drv, input logic rst_lvl,
                                   input logic [15:0] hold, input logic [7:0] rbyte,
                                   input logic fin);
    out_item_t s;
    s.slot_kind   = kind;
    s.clock_level = clk_lvl;
    s.data_level  = dat;
    s.data_driven = drv;
    s.reset_level = rst_lvl;
    s.wait_us     = hold;
    s.read_byte   = rbyte;
    s.last        = fin;
    expected_slots.push_back(s);
  endfunction

  // Work out the run of pin slots that one operation produces.
  function automatic void predict_slots(input in_item_t op);
    int          i;
    logic        rd;
    logic        rl;
    logic [15:0] hold;
    rl   = reset_line_q;
    hold = timing_reg[REG_HOLD];
    case (op.cmd)
      CMD_ENTER: begin
        // Reset pulse low, high, low, then the key MSB first with the clock rising.
        add_slot(KIND_STATIC, 1'b0, 1'b0, 1'b1, 1'b0, hold, 8'h00, 1'b0);
        add_slot(KIND_STATIC, 1'b0, 1'b0, 1'b1, 1'b1, FIXED_GAP_US, 8'h00, 1'b0);
        add_slot(KIND_STATIC, 1'b0, 1'b0, 1'b1, 1'b0, timing_reg[REG_ENTRY], 8'h00, 1'b0);
        for (i = KEY_BITS - 1; i >= 0; i--)
          add_slot(KIND_RISE, 1'b0, ENTRY_KEY[i], 1'b1, 1'b0, hold, 8'h00, 1'b0);
        add_slot(KIND_STATIC, 1'b0, 1'b0, 1'b1, 1'b0, FIXED_GAP_US, 8'h00, 1'b0);
        add_slot(KIND_STATIC, 1'b0, 1'b0, 1'b1, 1'b1, FIXED_GAP_US, 8'h00, 1'b1);
        reset_line_q = 1'b1;
      end
      CMD_EXIT: begin
        add_slot(KIND_STATIC, 1'b0, 1'b0, 1'b1, rl, hold, 8'h00, 1'b0);
        add_slot(KIND_STATIC, 1'b0, 1'b0, 1'b1, 1'b0, hold, 8'h00, 1'b0);
        add_slot(KIND_STATIC, 1'b0, 1'b0, 1'b1, 1'b1, 16'd0, 8'h00, 1'b1);
        reset_line_q = 1'b1;
      end
      CMD_XFER: begin
        // The code goes out LSB first, then a gap.
        for (i = 0; i < 4; i++)
          add_slot(KIND_FALL, 1'b0, op.icsp_code[i], 1'b1, rl, hold, 8'h00, 1'b0);
        add_slot(KIND_STATIC, 1'b0, 1'b0, 1'b1, rl, timing_reg[REG_A_CODE], 8'h00, 1'b0);
        rd = (op.icsp_code == CODE_READ_TABLE) ||
             ((op.icsp_code >= CODE_READ_LO) && (op.icsp_code <= CODE_READ_HI));
        if (rd) begin
          // Idle clocks, turnaround, then the reply sampled LSB first.
          for (i = 0; i < 8; i++)
            add_slot(KIND_FALL, 1'b0, 1'b0, 1'b1, rl, hold, 8'h00, 1'b0);
          add_slot(KIND_STATIC, 1'b0, 1'b0, 1'b1, rl, timing_reg[REG_TURN], 8'h00, 1'b0);
          for (i = 0; i < 8; i++)
            add_slot(KIND_SAMPLE, 1'b0, op.target_reply[i], 1'b0, rl, hold, 8'h00, 1'b0);
          add_slot(KIND_STATIC, 1'b0, 1'b0, 1'b1, rl, timing_reg[REG_A_DATA],
                   op.target_reply, 1'b1);
        end else begin
          for (i = 0; i < 16; i++)
            add_slot(KIND_FALL, 1'b0, op.payload[i], 1'b1, rl, hold, 8'h00, 1'b0);
          add_slot(KIND_STATIC, 1'b0, 1'b0, 1'b1, rl, timing_reg[REG_A_DATA], 8'h00, 1'b1);
        end
      end
      default: begin
        // Programming pulse: falling clock slots, clock held high, discharge, sixteen zero bits.
        for (i = 0; i < 3; i++)
          add_slot(KIND_FALL, 1'b0, 1'b0, 1'b1, rl, hold, 8'h00, 1'b0);
        add_slot(KIND_STATIC, 1'b1, 1'b0, 1'b1, rl, timing_reg[REG_PROG], 8'h00, 1'b0);
        add_slot(KIND_STATIC, 1'b0, 1'b0, 1'b1, rl, timing_reg[REG_DISCH], 8'h00, 1'b0);
        for (i = 0; i < 16; i++)
          add_slot(KIND_FALL, 1'b0, 1'b0, 1'b1, rl, hold, 8'h00, 1'b0);
        add_slot(KIND_STATIC, 1'b0, 1'b0, 1'b1, rl, timing_reg[REG_A_DATA], 8'h00, 1'b1);
      end
    endcase
  endfunction

  // Value of one timing register under a given setting.
  function automatic logic [15:0] timing_value(input timing_set_t setting, input int idx);
    case (setting)
      SET_ZERO:   return 16'h0000;
      SET_ONES:   return 16'hFFFF;
      SET_RANDOM: return 16'($urandom_range(0, 65535));
      SET_MIXED:  return idx[0] ? 16'hFFFF : 16'($urandom_range(0, 40));
      default: begin
        case (idx[CFG_IDX_W-1:0])
          REG_SETUP:  return RST_SETUP;
          REG_HOLD:   return RST_HOLD;
          REG_A_CODE: return RST_A_CODE;
          REG_A_DATA: return RST_A_DATA;
          REG_TURN:   return RST_TURN;
          REG_PROG:   return RST_PROG;
          REG_DISCH:  return RST_DISCH;
          default:    return RST_ENTRY;
        endcase
      end
    endcase
  endfunction

  // Random operation, biased toward transfers and toward the read codes.
  function automatic in_item_t random_op();
    in_item_t    op;
    int unsigned pick;
    pick            = $urandom_range(0, 19);
    op.icsp_code    = 4'($urandom_range(0, 15));
    op.payload      = 16'($urandom);
    op.target_reply = 8'($urandom);
    if (pick < 2)
      op.cmd = CMD_ENTER;
    else if (pick < 4)
      op.cmd = CMD_EXIT;
    else if (pick < 6)
      op.cmd = CMD_PULSE;
    else
      op.cmd = CMD_XFER;
    if ($urandom_range(0, 2) == 0)
      op.icsp_code = CODE_READ_LO + 4'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0: begin
        op.payload      = 16'h0000;
        op.target_reply = 8'h00;
      end
      1: begin
        op.payload      = 16'hFFFF;
        op.target_reply = 8'hFF;
      end
      default: ;
    endcase
    return op;
  endfunction

  function automatic string slot_str(input out_item_t s);
    return $sformatf("kind=%0d clk=%0d data=%0d drv=%0d rst=%0d wait=%0d byte=%02h last=%0d",
                     s.slot_kind, s.clock_level, s.data_level, s.data_driven,
                     s.reset_level, s.wait_us, s.read_byte, s.last);
  endfunction

  // Offer one operation, wait for its transfer, then queue its expected slots.
  task automatic send_op(input in_item_t op, input logic typed, input out_item_t final_slot);
    if (idle_enable && ($urandom_range(0, 5) == 0)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_stall);
    predict_slots(op);
    if (typed)
      expected_slots[expected_slots.size() - 1] = final_slot;
  endtask

  // Stop offering, wait for every expected slot, then let the block settle.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timing(input int idx, input logic [15:0] value);
    cfg_we          <= 1'b1;
    cfg_index       <= idx[CFG_IDX_W-1:0];
    cfg_wdata       <= value;
    timing_reg[idx] = value;
    @(posedge clk);
  endtask

  // Main sequence: reset, directed operations, then random phases under new timing.
  initial begin
    int          p;
    int          i;
    int unsigned n;
    timing_set_t plan [NUM_PHASES];
    plan = '{SET_ZERO, SET_ONES, SET_RANDOM, SET_MIXED, SET_RESET};
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    for (i = 0; i < 8; i++)
      timing_reg[i] = timing_value(SET_RESET, i);
    reset_line_q = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < NUM_DIRECTED; i++)
      send_op(DIRECTED_OPS[i].op, DIRECTED_OPS[i].typed, DIRECTED_OPS[i].final_slot);

    for (p = 0; p < NUM_PHASES; p++) begin
      drain_and_settle();
      idle_enable <= (p != NUM_PHASES - 1);
      for (i = 0; i < 8; i++)
        write_timing(i, timing_value(plan[p], i));
      cfg_we <= 1'b0;
      // Hold the output side off for a long stretch while operations keep coming.
      if (p == 2)
        pressure_start <= 1'b1;
      for (n = 0; n < OPS_PER_PHASE; n++)
        send_op(random_op(), 1'b0, '0);
    end
    drain_and_settle();

    if (mismatches == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  // Long receiver hold-off, counted here so the block fills up.
  initial begin
    wait (pressure_start);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Receiver stalls in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_run = 0;
      out_stall <= 1'b0;
    end else begin
      if (stall_run > 0)
        stall_run--;
      else if (idle_enable && ($urandom_range(0, 9) == 0))
        stall_run = $urandom_range(1, 16);
      out_stall <= long_hold || (stall_run != 0);
    end
  end

  // Compare every slot transfer with the oldest expected slot.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_slots.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: slot with none expected: %s", $time, slot_str(out_data));
      end else begin
        want = expected_slots.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: slot mismatch\n  expected %s\n  actual   %s",
                     $time, slot_str(want), slot_str(out_data));
        end
      end
    end
  end

  // Run limit.
  initial begin
    #12_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
